// ===== sv/oaht_pkg.sv =====
// oaht_pkg: shared constants, types and codes of the open addressing hash table
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package oaht_pkg;

  // slot count, a power of two
  localparam int unsigned SLOTS = 256;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned FILL_W = IDX_W + 1;
  localparam int unsigned OP_W = 2;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned LIM_W = 8;
  localparam logic [LIM_W-1:0] FILL_LIMIT_RST = LIM_W'(192);

  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_ADD = 2'd2,
    OP_DEL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stop;
  } status_t;

endpackage

// ===== sv/oaht_req_if.sv =====
// oaht_req_if: request channel, one word per get, set, add or delete
// depends on oaht_pkg
interface oaht_req_if;
  logic                          valid;
  logic                          ready;
  oaht_pkg::op_e                 op;
  logic [oaht_pkg::KEY_W-1:0]    key_id;
  logic [oaht_pkg::HASH_W-1:0]   key_hash;
  logic [oaht_pkg::VAL_W-1:0]    new_value;

  modport source (output valid, op, key_id, key_hash, new_value, input ready);
  modport sink (input valid, op, key_id, key_hash, new_value, output ready);
endinterface

// ===== sv/oaht_rsp_if.sv =====
// oaht_rsp_if: response channel, one word per request
// depends on oaht_pkg
interface oaht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        flag;
  logic [oaht_pkg::VAL_W-1:0]  read_value;
  logic                        table_full;

  modport source (output valid, flag, read_value, table_full, input ready);
  modport sink (input valid, flag, read_value, table_full, output ready);
endinterface

// ===== sv/oaht_ctrl.sv =====
// oaht_ctrl: state machine for the clearing pass, request intake and probe sequencing
// depends on oaht_pkg; drives the command struct of oaht_dp
module oaht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  oaht_pkg::status_t status_i,
  output oaht_pkg::cmd_t    cmd_o
);

  oaht_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             can_finish;

  assign can_finish = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oaht_pkg::ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      oaht_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = oaht_pkg::ST_PROBE;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (status_i.stop && can_finish) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      default: state_d = oaht_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      oaht_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      oaht_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      oaht_pkg::ST_PROBE: begin
        cmd_o.step   = !status_i.stop;
        cmd_o.finish = status_i.stop && can_finish;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/oaht_dp.sv =====
// oaht_dp: slot and value memories, probe address, tombstone tracking, fill count
// depends on oaht_pkg; sequenced by oaht_ctrl
module oaht_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  oaht_pkg::cmd_t               cmd_i,
  output oaht_pkg::status_t            status_o,
  input  logic                         cfg_we_i,
  input  logic [oaht_pkg::LIM_W-1:0]   cfg_wdata_i,
  input  oaht_pkg::op_e                op_i,
  input  logic [oaht_pkg::KEY_W-1:0]   key_id_i,
  input  logic [oaht_pkg::HASH_W-1:0]  key_hash_i,
  input  logic [oaht_pkg::VAL_W-1:0]   new_value_i,
  output logic                         flag_o,
  output logic [oaht_pkg::VAL_W-1:0]   read_value_o,
  output logic                         table_full_o
);

  localparam int unsigned IW = oaht_pkg::IDX_W;
  localparam int unsigned KW = oaht_pkg::KEY_W;
  localparam int unsigned VW = oaht_pkg::VAL_W;

  // slot entry: tombstone bit above the key
  logic [KW:0]   slot_mem [oaht_pkg::SLOTS];
  logic [VW-1:0] val_mem  [oaht_pkg::SLOTS];

  logic [KW:0]   slot_rd_q;
  logic [VW-1:0] val_rd_q;

  logic [IW-1:0] at_q, at_d, at_next;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] tomb_at_q, tomb_at_d;
  logic          tomb_seen_q, tomb_seen_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [oaht_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [oaht_pkg::LIM_W-1:0]  lim_q;

  oaht_pkg::op_e req_op_q;
  logic [KW-1:0] req_key_q;
  logic [VW-1:0] req_val_q;

  logic          flag_q, full_q;
  logic [VW-1:0] rdv_q;

  logic [KW-1:0] cur_key;
  logic          cur_tomb, cur_empty, cur_hit, cur_is_tomb, key_zero, last;
  logic          tseen, fresh, have_dest, refuse;
  logic [IW-1:0] tat, dest;

  logic          res_flag, res_full, fill_inc;
  logic [VW-1:0] res_rdv;
  logic          slot_we, val_we, dec_slot_we, dec_val_we;
  logic [IW-1:0] wr_addr, dec_addr;
  logic [KW:0]   slot_wdata, dec_slot_wdata;

  assign cur_key     = slot_rd_q[KW-1:0];
  assign cur_tomb    = slot_rd_q[KW];
  assign key_zero    = (req_key_q == '0);
  assign cur_empty   = (cur_key == '0) && !cur_tomb;
  assign cur_is_tomb = (cur_key == '0) && cur_tomb;
  assign cur_hit     = (cur_key != '0) && (cur_key == req_key_q);
  assign last        = (cnt_q == IW'(oaht_pkg::SLOTS - 1));

  assign status_o.stop     = key_zero || cur_empty || cur_hit || last;
  assign status_o.clr_last = (clr_q == IW'(oaht_pkg::SLOTS - 1));

  assign at_next = (at_q == IW'(oaht_pkg::SLOTS - 1)) ? '0 : at_q + IW'(1);

  always_comb begin
    if (cmd_i.load) begin
      at_d = key_hash_i[IW-1:0];
    end else if (cmd_i.step) begin
      at_d = at_next;
    end else begin
      at_d = at_q;
    end
  end

  // insertion target
  assign tseen     = tomb_seen_q || cur_is_tomb;
  assign tat       = tomb_seen_q ? tomb_at_q : at_q;
  assign fresh     = cur_empty && !tomb_seen_q;
  assign have_dest = cur_empty || tseen;
  assign dest      = fresh ? at_q : tat;
  assign refuse    = !have_dest ||
                     (fresh && (fill_q >= {1'b0, lim_q}));

  always_comb begin
    res_flag       = 1'b0;
    res_full       = 1'b0;
    res_rdv        = '0;
    fill_inc       = 1'b0;
    dec_slot_we    = 1'b0;
    dec_val_we     = 1'b0;
    dec_addr       = at_q;
    dec_slot_wdata = {1'b0, req_key_q};
    if (!key_zero) begin
      unique case (req_op_q)
        oaht_pkg::OP_GET: begin
          if (cur_hit) begin
            res_flag = 1'b1;
            res_rdv  = val_rd_q;
          end
        end
        oaht_pkg::OP_DEL: begin
          if (cur_hit) begin
            res_flag       = 1'b1;
            dec_slot_we    = 1'b1;
            dec_slot_wdata = {1'b1, {KW{1'b0}}};
          end
        end
        oaht_pkg::OP_SET, oaht_pkg::OP_ADD: begin
          if (cur_hit) begin
            dec_val_we = (req_op_q == oaht_pkg::OP_SET);
          end else if (refuse) begin
            res_full = 1'b1;
          end else begin
            res_flag    = 1'b1;
            dec_slot_we = 1'b1;
            dec_val_we  = 1'b1;
            dec_addr    = dest;
            fill_inc    = fresh;
          end
        end
        default: res_flag = 1'b0;
      endcase
    end
  end

  always_comb begin
    slot_we    = cmd_i.finish && dec_slot_we;
    val_we     = cmd_i.finish && dec_val_we;
    wr_addr    = dec_addr;
    slot_wdata = dec_slot_wdata;
    if (cmd_i.clr_step) begin
      slot_we    = 1'b1;
      wr_addr    = clr_q;
      slot_wdata = '0;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    tomb_seen_d = tomb_seen_q;
    tomb_at_d   = tomb_at_q;
    if (cmd_i.load) begin
      cnt_d       = '0;
      tomb_seen_d = 1'b0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + IW'(1);
      if (cur_is_tomb && !tomb_seen_q) begin
        tomb_seen_d = 1'b1;
        tomb_at_d   = at_q;
      end
    end
  end

  assign clr_d  = cmd_i.clr_step ? clr_q + IW'(1) : clr_q;
  assign fill_d = (cmd_i.finish && fill_inc) ? fill_q + oaht_pkg::FILL_W'(1) : fill_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[wr_addr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[at_d];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= req_val_q;
    end
    val_rd_q <= val_mem[at_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q        <= '0;
      cnt_q       <= '0;
      tomb_seen_q <= 1'b0;
      tomb_at_q   <= '0;
      clr_q       <= '0;
      fill_q      <= '0;
      lim_q       <= oaht_pkg::FILL_LIMIT_RST;
    end else begin
      at_q        <= at_d;
      cnt_q       <= cnt_d;
      tomb_seen_q <= tomb_seen_d;
      tomb_at_q   <= tomb_at_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q  <= op_i;
      req_key_q <= key_id_i;
      req_val_q <= new_value_i;
    end
    if (cmd_i.finish) begin
      flag_q <= res_flag;
      rdv_q  <= res_rdv;
      full_q <= res_full;
    end
  end

  assign flag_o       = flag_q;
  assign read_value_o = rdv_q;
  assign table_full_o = full_q;

endmodule

// ===== sv/open_addressing_hash_table.sv =====
// open_addressing_hash_table: linear probing key/value table with tombstones
// a request probes 1 to 256 slots, from the one its hash selects, before its response is registered
// requests are taken only while idle, so the next is not accepted until the last one's probe ends
// a response waiting on the output register does not block the next request's intake
// reset: asynchronous active low; a clearing pass over all 256 slots of the slot memory follows,
// request ready stays low until it ends; configuration writes are taken throughout
module open_addressing_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [oaht_pkg::LIM_W-1:0]  cfg_wdata_i,
  oaht_req_if.sink                    req,
  oaht_rsp_if.source                  rsp
);

  oaht_pkg::cmd_t    cmd;
  oaht_pkg::status_t status;

  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  oaht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (req.op),
    .key_id_i     (req.key_id),
    .key_hash_i   (req.key_hash),
    .new_value_i  (req.new_value),
    .flag_o       (rsp.flag),
    .read_value_o (rsp.read_value),
    .table_full_o (rsp.table_full)
  );

endmodule

// ===== sim/tb_open_addressing_hash_table.sv =====
// tb_open_addressing_hash_table: self-checking bench for the linear probing key/value table
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if and open_addressing_hash_table; predicts
// every response word in-bench and checks it in order under random request gaps and stalls
module tb_open_addressing_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    oaht_pkg::op_e                 op;
    logic [oaht_pkg::KEY_W-1:0]    key_id;
    logic [oaht_pkg::HASH_W-1:0]   key_hash;
    logic [oaht_pkg::VAL_W-1:0]    new_value;
  } request_t;

  typedef struct {
    logic                          flag;
    logic [oaht_pkg::VAL_W-1:0]    read_value;
    logic                          table_full;
  } answer_t;

  typedef struct {
    logic [oaht_pkg::KEY_W-1:0]    id;
    logic [oaht_pkg::HASH_W-1:0]   hash;
  } known_key_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [oaht_pkg::LIM_W-1:0]  cfg_wdata_i;

  oaht_req_if req_bus ();
  oaht_rsp_if rsp_bus ();

  open_addressing_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // shadow of the slot store
  logic [oaht_pkg::KEY_W-1:0]  slot_id   [oaht_pkg::SLOTS];
  bit                          slot_dead [oaht_pkg::SLOTS];
  logic [oaht_pkg::VAL_W-1:0]  slot_data [oaht_pkg::SLOTS];
  int unsigned                 fill_used;
  logic [oaht_pkg::LIM_W-1:0]  fill_limit_shadow;

  request_t    request_q[$];
  answer_t     answer_q[$];
  known_key_t  key_pool[$];
  request_t    next_word;
  answer_t     want;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned stall;
  bit          send_rush;
  bit          recv_rush;
  int unsigned mismatch_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic answer_t apply_request(request_t r);
    answer_t                     a;
    logic [oaht_pkg::IDX_W-1:0]  at;
    logic [oaht_pkg::IDX_W-1:0]  tomb_at;
    logic [oaht_pkg::IDX_W-1:0]  hit_at;
    logic [oaht_pkg::IDX_W-1:0]  dest;
    bit                          tomb_seen;
    bit                          hit;
    bit                          have_dest;
    bit                          fresh;
    int                          n;
    a.flag = 1'b0;
    a.read_value = '0;
    a.table_full = 1'b0;
    tomb_seen = 1'b0;
    hit = 1'b0;
    have_dest = 1'b0;
    fresh = 1'b0;
    tomb_at = '0;
    hit_at = '0;
    dest = '0;
    if (r.key_id == '0) return a;
    at = r.key_hash[oaht_pkg::IDX_W-1:0];
    for (n = 0; n < oaht_pkg::SLOTS && !hit && !have_dest; n++) begin
      if (slot_id[at] == '0) begin
        if (!slot_dead[at]) begin
          have_dest = 1'b1;
          fresh = !tomb_seen;
          dest = tomb_seen ? tomb_at : at;
        end else if (!tomb_seen) begin
          tomb_seen = 1'b1;
          tomb_at = at;
        end
      end else if (slot_id[at] == r.key_id) begin
        hit = 1'b1;
        hit_at = at;
      end
      at = at + 1'b1;
    end
    if (!hit && !have_dest && tomb_seen) begin
      have_dest = 1'b1;
      dest = tomb_at;
    end
    case (r.op)
      oaht_pkg::OP_GET: begin
        if (hit) begin
          a.flag = 1'b1;
          a.read_value = slot_data[hit_at];
        end
      end
      oaht_pkg::OP_DEL: begin
        if (hit) begin
          slot_id[hit_at] = '0;
          slot_dead[hit_at] = 1'b1;
          a.flag = 1'b1;
        end
      end
      default: begin
        if (hit) begin
          if (r.op == oaht_pkg::OP_SET) slot_data[hit_at] = r.new_value;
        end else if (!have_dest || (fresh && fill_used >= fill_limit_shadow)) begin
          a.table_full = 1'b1;
        end else begin
          if (fresh) fill_used++;
          slot_id[dest] = r.key_id;
          slot_dead[dest] = 1'b0;
          slot_data[dest] = r.new_value;
          a.flag = 1'b1;
        end
      end
    endcase
    return a;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.op <= oaht_pkg::OP_GET;
      req_bus.key_id <= '0;
      req_bus.key_hash <= '0;
      req_bus.new_value <= '0;
      send_gap <= 0;
      send_rush <= 1'b0;
    end else if (!(req_bus.valid && !req_bus.ready)) begin
      if (req_bus.valid) begin
        answer_q.push_back(apply_request('{op: req_bus.op, key_id: req_bus.key_id,
                                           key_hash: req_bus.key_hash,
                                           new_value: req_bus.new_value}));
      end
      if (send_gap != 0 || request_q.size() == 0) begin
        req_bus.valid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end else begin
        next_word = request_q.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.op <= next_word.op;
        req_bus.key_id <= next_word.key_id;
        req_bus.key_hash <= next_word.key_hash;
        req_bus.new_value <= next_word.new_value;
        if ($urandom_range(0, 15) == 0) send_rush <= !send_rush;
        send_gap <= send_rush ? 0 : $urandom_range(0, 14);
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      recv_gap <= 0;
      recv_rush <= 1'b0;
    end else if (rsp_bus.valid && rsp_bus.ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected word flag %0d read_value %h table_full %0d", $time,
                 rsp_bus.flag, rsp_bus.read_value, rsp_bus.table_full);
        mismatch_count++;
      end else begin
        want = answer_q.pop_front();
        if (rsp_bus.flag !== want.flag) begin
          $display("%0t: flag expected %0d actual %0d", $time, want.flag, rsp_bus.flag);
          mismatch_count++;
        end
        if (rsp_bus.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   rsp_bus.read_value);
          mismatch_count++;
        end
        if (rsp_bus.table_full !== want.table_full) begin
          $display("%0t: table_full expected %0d actual %0d", $time, want.table_full,
                   rsp_bus.table_full);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 15) == 0) recv_rush <= !recv_rush;
      stall = recv_rush ? 0 : $urandom_range(0, 14);
      rsp_bus.ready <= (stall == 0);
      recv_gap <= (stall == 0) ? 0 : stall - 1;
    end else if (!rsp_bus.ready) begin
      if (recv_gap == 0) rsp_bus.ready <= 1'b1;
      else recv_gap <= recv_gap - 1;
    end
  end

  task automatic push_req(oaht_pkg::op_e op, logic [oaht_pkg::KEY_W-1:0] id,
                          logic [oaht_pkg::HASH_W-1:0] hash,
                          logic [oaht_pkg::VAL_W-1:0] value);
    request_q.push_back('{op: op, key_id: id, key_hash: hash, new_value: value});
  endtask

  task automatic wait_for_drain();
    while (request_q.size() != 0 || req_bus.valid || answer_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_fill_limit(logic [oaht_pkg::LIM_W-1:0] value);
    wait_for_drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fill_limit_shadow = value;
  endtask

  // mostly well-formed traffic over a pool of keys with stable hashes, some noise
  task automatic push_random(int count, int insert_pct, int fresh_pct);
    known_key_t     k;
    oaht_pkg::op_e  op;
    int             roll;
    int             i;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) op = $urandom_range(0, 1) ? oaht_pkg::OP_SET : oaht_pkg::OP_ADD;
      else if ($urandom_range(0, 2) != 0) op = oaht_pkg::OP_GET;
      else op = oaht_pkg::OP_DEL;
      if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
        k.id = $urandom;
        k.hash = $urandom;
        // clustered start slots around the wrap point
        if ($urandom_range(0, 1)) begin
          k.hash[oaht_pkg::IDX_W-1:0] =
            oaht_pkg::IDX_W'(oaht_pkg::SLOTS - 8 + $urandom_range(0, 15));
        end
        if (k.id != '0) key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) k.id = '0;
      else if (roll < 6) k.hash = $urandom;
      push_req(op, k.id, k.hash, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    fill_used = 0;
    fill_limit_shadow = oaht_pkg::FILL_LIMIT_RST;
    for (int s = 0; s < oaht_pkg::SLOTS; s++) begin
      slot_id[s] = '0;
      slot_dead[s] = 1'b0;
      slot_data[s] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, reserved key, update paths, wrap, tombstones
    push_req(oaht_pkg::OP_GET, 32'h0000_0001, 32'hA5A5_0005, '1);
    push_req(oaht_pkg::OP_DEL, 32'h0000_0001, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_SET, 32'h0000_0000, 32'hA5A5_0005, '1);
    push_req(oaht_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, '1);
    push_req(oaht_pkg::OP_DEL, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    push_req(oaht_pkg::OP_GET, 32'h0000_0000, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_SET, 32'h0000_0001, 32'hA5A5_0005, '1);
    push_req(oaht_pkg::OP_GET, 32'h0000_0001, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_ADD, 32'h0000_0001, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_SET, 32'h0000_0001, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_GET, 32'h0000_0001, 32'hA5A5_0005, '1);
    push_req(oaht_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
    push_req(oaht_pkg::OP_SET, 32'h1357_9BDF, 32'h0000_00FF, 64'h5A5A_A5A5_0F0F_F0F0);
    push_req(oaht_pkg::OP_GET, 32'h1357_9BDF, 32'h0000_00FF, '0);
    push_req(oaht_pkg::OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    push_req(oaht_pkg::OP_GET, 32'h1357_9BDF, 32'h0000_00FF, '0);
    push_req(oaht_pkg::OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    push_req(oaht_pkg::OP_ADD, 32'h8000_0000, 32'h1234_5FFF, 64'hFFFF_0000_FFFF_0000);
    push_req(oaht_pkg::OP_GET, 32'h8000_0000, 32'h1234_5FFF, '0);
    push_req(oaht_pkg::OP_ADD, 32'h1357_9BDF, 32'h0000_00FF, '1);
    push_req(oaht_pkg::OP_DEL, 32'h0000_0001, 32'hA5A5_0005, '0);
    push_req(oaht_pkg::OP_GET, 32'h0000_0001, 32'hA5A5_0005, '0);

    // limit of zero: fresh slots refused, tombstone reuse and updates still taken
    set_fill_limit(8'd0);
    push_req(oaht_pkg::OP_SET, 32'h2468_ACE0, 32'h0F0F_0077, '1);
    push_req(oaht_pkg::OP_DEL, 32'h8000_0000, 32'h1234_5FFF, '0);
    push_req(oaht_pkg::OP_SET, 32'h7777_0001, 32'h0000_00FF, 64'h0123_4567_89AB_CDEF);
    push_req(oaht_pkg::OP_SET, 32'h1357_9BDF, 32'h0000_00FF, 64'hFEDC_BA98_7654_3210);
    push_req(oaht_pkg::OP_GET, 32'h1357_9BDF, 32'h0000_00FF, '0);
    push_random(30, 50, 40);

    set_fill_limit(8'd1);
    push_random(20, 50, 40);

    set_fill_limit(8'd60);
    push_random(100, 50, 40);

    // near full table with long probe chains
    set_fill_limit(8'd255);
    push_random(220, 90, 90);

    set_fill_limit(8'd128);
    push_random(80, 40, 30);

    wait_for_drain();
    repeat (oaht_pkg::SLOTS + 16) @(posedge clk_i);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
